### src/cal_pkg.sv
// Shared types, codes and constants for the cursor array list unit.
package cal_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W       = 4;
    localparam int VALUE_W    = 32;
    localparam int TGT_W      = 10;
    localparam int DATA_OUT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int CURSOR_W   = 10;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 4'd0,
        OP_INSERT   = 4'd1,
        OP_REMOVE   = 4'd2,
        OP_GO_TO    = 4'd3,
        OP_NEXT     = 4'd4,
        OP_PREVIOUS = 4'd5,
        OP_TO_START = 4'd6,
        OP_TO_END   = 4'd7,
        OP_READ     = 4'd8
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_INS_WR,
        S_REM_DATA,
        S_REM_CHK,
        S_REM_WR,
        S_RD_DATA,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        ADDR_COUNT,
        ADDR_CURSOR,
        ADDR_TGT,
        ADDR_PTR,
        ADDR_PTR_M1,
        ADDR_PTR_P1
    } t_addr_sel;

    typedef enum logic {
        WD_VALUE,
        WD_RDATA
    } t_wd_sel;

    typedef enum logic [2:0] {
        CUR_KEEP,
        CUR_TGT,
        CUR_NEXT,
        CUR_PREV,
        CUR_ZERO,
        CUR_END
    } t_cur_op;

    typedef enum logic [2:0] {
        PTR_KEEP,
        PTR_COUNT,
        PTR_CURSOR,
        PTR_DEC,
        PTR_INC
    } t_ptr_op;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [TGT_W-1:0]   target_index;
    } t_in_word;

    typedef struct packed {
        logic [DATA_OUT_W-1:0] data;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
        logic [CURSOR_W-1:0]   cursor;
    } t_out_word;

    typedef struct packed {
        logic      load_in;
        logic      set_res;
        t_status   res_status;
        logic      cap_data;
        logic      mem_we;
        t_addr_sel waddr_sel;
        t_wd_sel   wd_sel;
        logic      mem_re;
        t_addr_sel raddr_sel;
        logic      count_inc;
        logic      count_dec;
        t_cur_op   cur_op;
        t_ptr_op   ptr_op;
        logic      emit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic cur_at_end;
        logic tgt_oor;
        logic ptr_at_cursor;
        logic ptr_last;
        logic out_free;
    } t_stat;

endpackage

### src/cal_ctrl.sv
// Controller state machine that sequences each list operation.
module cal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cal_pkg::t_stat i_stat,
    output cal_pkg::t_cmd  o_cmd
);
    import cal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_stat.op)
                    OP_INSERT: begin
                        if (!i_stat.full) begin
                            n_state = S_INS_CHK;
                        end
                    end
                    OP_REMOVE: begin
                        if (!i_stat.empty && !i_stat.cur_at_end) begin
                            n_state = S_REM_DATA;
                        end
                    end
                    OP_GO_TO: begin
                        if (!i_stat.tgt_oor) begin
                            n_state = S_RD_DATA;
                        end
                    end
                    OP_READ: begin
                        if (!i_stat.empty && !i_stat.cur_at_end) begin
                            n_state = S_RD_DATA;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_INS_CHK: begin
                n_state = i_stat.ptr_at_cursor ? S_FINISH : S_INS_WR;
            end
            S_INS_WR: begin
                n_state = S_INS_CHK;
            end
            S_REM_DATA: begin
                n_state = S_REM_CHK;
            end
            S_REM_CHK: begin
                n_state = i_stat.ptr_last ? S_FINISH : S_REM_WR;
            end
            S_REM_WR: begin
                n_state = S_REM_CHK;
            end
            S_RD_DATA: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = ST_OK;
                case (i_stat.op)
                    OP_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.mem_we    = 1'b1;
                            o_cmd.waddr_sel = ADDR_COUNT;
                            o_cmd.wd_sel    = WD_VALUE;
                            o_cmd.count_inc = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.ptr_op = PTR_COUNT;
                        end
                    end
                    OP_REMOVE, OP_READ: begin
                        if (i_stat.empty) begin
                            o_cmd.res_status = ST_EMPTY;
                        end else if (i_stat.cur_at_end) begin
                            o_cmd.res_status = ST_RANGE;
                        end else begin
                            o_cmd.mem_re    = 1'b1;
                            o_cmd.raddr_sel = ADDR_CURSOR;
                            o_cmd.ptr_op    = PTR_CURSOR;
                        end
                    end
                    OP_GO_TO: begin
                        if (i_stat.tgt_oor) begin
                            o_cmd.res_status = ST_RANGE;
                        end else begin
                            o_cmd.mem_re    = 1'b1;
                            o_cmd.raddr_sel = ADDR_TGT;
                            o_cmd.cur_op    = CUR_TGT;
                        end
                    end
                    OP_NEXT:     o_cmd.cur_op = CUR_NEXT;
                    OP_PREVIOUS: o_cmd.cur_op = CUR_PREV;
                    OP_TO_START: o_cmd.cur_op = CUR_ZERO;
                    OP_TO_END:   o_cmd.cur_op = CUR_END;
                    default:     o_cmd.cur_op = CUR_KEEP;
                endcase
            end
            S_INS_CHK: begin
                if (i_stat.ptr_at_cursor) begin
                    o_cmd.mem_we    = 1'b1;
                    o_cmd.waddr_sel = ADDR_CURSOR;
                    o_cmd.wd_sel    = WD_VALUE;
                    o_cmd.count_inc = 1'b1;
                end else begin
                    o_cmd.mem_re    = 1'b1;
                    o_cmd.raddr_sel = ADDR_PTR_M1;
                end
            end
            S_INS_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_sel = ADDR_PTR;
                o_cmd.wd_sel    = WD_RDATA;
                o_cmd.ptr_op    = PTR_DEC;
            end
            S_REM_DATA: begin
                o_cmd.cap_data = 1'b1;
            end
            S_REM_CHK: begin
                if (i_stat.ptr_last) begin
                    o_cmd.count_dec = 1'b1;
                end else begin
                    o_cmd.mem_re    = 1'b1;
                    o_cmd.raddr_sel = ADDR_PTR_P1;
                end
            end
            S_REM_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_sel = ADDR_PTR;
                o_cmd.wd_sel    = WD_RDATA;
                o_cmd.ptr_op    = PTR_INC;
            end
            S_RD_DATA: begin
                o_cmd.cap_data = 1'b1;
            end
            S_FINISH: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### src/cal_dpath.sv
// Datapath of the cursor array list: entry memory, count, cursor and result register.
module cal_dpath #(
    parameter int CAPACITY   = cal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = cal_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cal_pkg::t_in_word  i_in_word,
    input  cal_pkg::t_cmd      i_cmd,
    output cal_pkg::t_stat     o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output cal_pkg::t_out_word o_out_word
);
    import cal_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > TGT_W) ? CW : TGT_W;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [OP_W-1:0]       r_op;
    logic [DATA_WIDTH-1:0] r_value;
    logic [TGT_W-1:0]      r_tgt;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [AW-1:0]         r_cursor;
    logic [AW-1:0]         n_cursor;
    logic [AW-1:0]         r_ptr;
    logic [AW-1:0]         n_ptr;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] r_res_data;
    t_status               r_res_status;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata;

    function automatic logic [AW-1:0] sel_addr(input t_addr_sel sel,
                                               input logic [CW-1:0] count,
                                               input logic [AW-1:0] cursor,
                                               input logic [TGT_W-1:0] tgt,
                                               input logic [AW-1:0] ptr);
        logic [AW-1:0] addr;
        case (sel)
            ADDR_COUNT:  addr = AW'(count);
            ADDR_CURSOR: addr = cursor;
            ADDR_TGT:    addr = AW'(tgt);
            ADDR_PTR_M1: addr = ptr - AW'(1);
            ADDR_PTR_P1: addr = ptr + AW'(1);
            default:     addr = ptr;
        endcase
        return addr;
    endfunction

    always_comb begin
        w_waddr = sel_addr(i_cmd.waddr_sel, r_count, r_cursor, r_tgt, r_ptr);
        w_raddr = sel_addr(i_cmd.raddr_sel, r_count, r_cursor, r_tgt, r_ptr);
        w_wdata = (i_cmd.wd_sel == WD_VALUE) ? r_value : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.mem_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.count_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_cursor = r_cursor;
        case (i_cmd.cur_op)
            CUR_TGT: n_cursor = AW'(r_tgt);
            CUR_NEXT: begin
                if (CW'(r_cursor) + CW'(1) < r_count) begin
                    n_cursor = r_cursor + AW'(1);
                end
            end
            CUR_PREV: begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - AW'(1);
                end
            end
            CUR_ZERO: n_cursor = '0;
            CUR_END:  n_cursor = (r_count == '0) ? '0 : AW'(r_count - CW'(1));
            default:  n_cursor = r_cursor;
        endcase
    end

    always_comb begin
        n_ptr = r_ptr;
        case (i_cmd.ptr_op)
            PTR_COUNT:  n_ptr = AW'(r_count);
            PTR_CURSOR: n_ptr = r_cursor;
            PTR_DEC:    n_ptr = r_ptr - AW'(1);
            PTR_INC:    n_ptr = r_ptr + AW'(1);
            default:    n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load_in) begin
            r_op    <= i_in_word.op;
            r_value <= DATA_WIDTH'(i_in_word.value);
            r_tgt   <= i_in_word.target_index;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_data   <= '0;
        end else if (i_cmd.cap_data) begin
            r_res_data <= r_rd_data;
        end
        if (i_cmd.emit) begin
            r_out_word.data   <= DATA_OUT_W'(r_res_data);
            r_out_word.status <= r_res_status;
            r_out_word.count  <= COUNT_W'(r_count);
            r_out_word.cursor <= CURSOR_W'(r_cursor);
        end
    end

    always_comb begin
        o_stat.op            = t_op'(r_op);
        o_stat.full          = (r_count >= CW'(CAPACITY));
        o_stat.empty         = (r_count == '0);
        o_stat.cur_at_end    = (CW'(r_cursor) >= r_count);
        o_stat.tgt_oor       = (CMPW'(r_tgt) >= CMPW'(r_count));
        o_stat.ptr_at_cursor = (r_ptr == r_cursor);
        o_stat.ptr_last      = (CW'(r_ptr) + CW'(1) == r_count);
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### src/cursor_array_list_unit.sv
// Top level of the cursor array list unit: controller, datapath and checks.
// An ordered list of up to CAPACITY words kept in a single-port-write,
// registered-read memory, with an entry count and a cursor. One input word
// is taken at a time and gives exactly one result word. Insert and remove
// move the entries behind the cursor one at a time through the memory, with
// one read and one write per moved entry. The unit accepts the next input
// word once a result is registered, even if that result has not been taken
// yet. No clearing pass is needed.
module cursor_array_list_unit #(
    parameter int CAPACITY   = cal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = cal_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cal_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cal_pkg::t_out_word o_out_word
);
    import cal_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cal_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result registered while the output slot is occupied");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("a second word was offered a slot before the first finished");

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !cmd.mem_we)
        else $error("memory written while a new word is accepted");

    a_grow_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.count_inc |-> !stat.full)
        else $error("count grown on a full list");

    a_shrink_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.count_dec |-> !stat.empty)
        else $error("count reduced on an empty list");

endmodule
